### hw/rtl/hkrb_pkg.sv
package hkrb_pkg;

   localparam int KEY_SLOTS_DEFAULT = 6;
   // key fields on the result channel
   localparam int SHOWN_SLOTS = 6;

   localparam logic [1:0] OP_PRESS   = 2'd0;
   localparam logic [1:0] OP_RELEASE = 2'd1;
   localparam logic [1:0] OP_SERVICE = 2'd2;
   localparam logic [1:0] OP_UNUSED  = 2'd3;

   localparam logic [1:0] ATT_NONE      = 2'd0;
   localparam logic [1:0] ATT_OK        = 2'd1;
   localparam logic [1:0] ATT_REFUSED   = 2'd2;
   localparam logic [1:0] ATT_NOT_READY = 2'd3;

   localparam logic [7:0] MOD_FIRST   = 8'hE0;
   localparam logic [7:0] MOD_LAST    = 8'hE7;
   localparam logic [7:0] USAGE_LIMIT = 8'hA5;

endpackage

### hw/rtl/hid_keyboard_report_builder_unit.sv
// Boot keyboard report builder with KEY_SLOTS key slots, a modifier byte and a
// release-pending flag. Each request (press, release all, service) yields one
// result, or two when a press first flushes a pending release that succeeds.
// A request is latched into the request register and each result is formed by
// one pass of logic into the result register, one result per cycle unless the
// result side stalls; the next request is taken in the cycle its last result
// is formed, and results back up only when the result side stalls.
module hid_keyboard_report_builder_unit #(
   parameter int KEY_SLOTS = hkrb_pkg::KEY_SLOTS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_op,
   input  logic [7:0] req_usage,
   input  logic       req_link_ready,
   input  logic       req_host_accepts,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_attempt,
   output logic [7:0] rsp_modifiers,
   output logic [7:0] rsp_key_0,
   output logic [7:0] rsp_key_1,
   output logic [7:0] rsp_key_2,
   output logic [7:0] rsp_key_3,
   output logic [7:0] rsp_key_4,
   output logic [7:0] rsp_key_5,
   output logic       rsp_success,
   output logic       rsp_release_owed,
   output logic       rsp_last
);

   localparam int ShowN = (KEY_SLOTS > hkrb_pkg::SHOWN_SLOTS) ? KEY_SLOTS
                                                              : hkrb_pkg::SHOWN_SLOTS;

   // request register
   logic       busy_ff, busy_in;
   logic       phase_ff, phase_in;
   logic [1:0] op_ff;
   logic [7:0] usage_ff;
   logic       ready_ff;
   logic       accepts_ff;

   // report state
   logic [7:0] mods_ff, mods_in;
   logic [7:0] slots_ff [KEY_SLOTS];
   logic [7:0] slots_in [KEY_SLOTS];
   logic       pending_ff, pending_in;

   // result register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [1:0] attempt_ff, attempt_in;
   logic [7:0] show_mods_ff, show_mods_in;
   logic [7:0] show_keys_ff [hkrb_pkg::SHOWN_SLOTS];
   logic [7:0] show_keys_in [hkrb_pkg::SHOWN_SLOTS];
   logic       success_ff, success_in;
   logic       owed_ff, owed_in;
   logic       last_ff, last_in;

   logic       out_free;
   logic       fire;
   logic       done;
   logic       accept;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign fire      = busy_ff && out_free;
   assign done      = fire && last_in;
   assign req_stall = busy_ff && !done;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      logic       ok;
      logic [1:0] send_att;
      logic       release_first;
      logic       do_release;
      logic       is_mod;
      logic       usage_ok;
      logic       taken;
      logic       added;
      logic [7:0] new_mods;
      logic [7:0] new_slots [KEY_SLOTS];
      logic [7:0] src_slots [KEY_SLOTS];
      logic [7:0] ext [ShowN];

      ok       = ready_ff && accepts_ff;
      send_att = ok ? hkrb_pkg::ATT_OK
                    : (ready_ff ? hkrb_pkg::ATT_REFUSED : hkrb_pkg::ATT_NOT_READY);

      release_first = (op_ff == hkrb_pkg::OP_PRESS) && pending_ff && !phase_ff;
      do_release    = release_first || (op_ff == hkrb_pkg::OP_RELEASE) ||
                      ((op_ff == hkrb_pkg::OP_SERVICE) && pending_ff && ready_ff);

      // press: modifier bit or first slot holding the usage or empty
      is_mod   = (usage_ff >= hkrb_pkg::MOD_FIRST) && (usage_ff <= hkrb_pkg::MOD_LAST);
      usage_ok = (usage_ff != 8'd0) && (usage_ff < hkrb_pkg::USAGE_LIMIT);
      new_mods = is_mod ? (mods_ff | (8'd1 << usage_ff[2:0])) : mods_ff;
      taken    = 1'b0;
      for (int i = 0; i < KEY_SLOTS; i++) begin
         new_slots[i] = slots_ff[i];
         if (!is_mod && usage_ok && !taken &&
             (slots_ff[i] == usage_ff || slots_ff[i] == 8'd0)) begin
            new_slots[i] = usage_ff;
            taken        = 1'b1;
         end
      end
      added = is_mod || taken;

      mods_in      = mods_ff;
      slots_in     = slots_ff;
      pending_in   = pending_ff;
      phase_in     = phase_ff;
      attempt_in   = hkrb_pkg::ATT_NONE;
      show_mods_in = mods_ff;
      src_slots    = slots_ff;
      success_in   = 1'b0;
      last_in      = 1'b1;

      if (do_release) begin
         show_mods_in = 8'd0;
         for (int i = 0; i < KEY_SLOTS; i++) begin
            src_slots[i] = 8'd0;
            slots_in[i]  = 8'd0;
         end
         mods_in    = 8'd0;
         attempt_in = send_att;
         success_in = ok;
         pending_in = !ok;
         last_in    = !(release_first && ok);
         phase_in   = release_first && ok;
      end else begin
         unique case (op_ff)
            hkrb_pkg::OP_PRESS: begin
               if (added) begin
                  show_mods_in = new_mods;
                  src_slots    = new_slots;
                  attempt_in   = send_att;
                  success_in   = ok;
                  if (ok) begin
                     mods_in  = new_mods;
                     slots_in = new_slots;
                  end else begin
                     mods_in    = 8'd0;
                     for (int i = 0; i < KEY_SLOTS; i++) slots_in[i] = 8'd0;
                     pending_in = 1'b1;
                  end
               end
            end
            hkrb_pkg::OP_SERVICE: success_in = !pending_ff;
            default:              success_in = 1'b0;
         endcase
      end
      owed_in = pending_in;

      ext = '{default: 8'd0};
      for (int i = 0; i < KEY_SLOTS; i++) ext[i] = src_slots[i];
      for (int j = 0; j < hkrb_pkg::SHOWN_SLOTS; j++) show_keys_in[j] = ext[j];

      busy_in = accept ? 1'b1 : (done ? 1'b0 : busy_ff);
      if (accept) phase_in = 1'b0;
      rsp_valid_in = fire ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         phase_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mods_ff      <= 8'd0;
         pending_ff   <= 1'b0;
         for (int i = 0; i < KEY_SLOTS; i++) slots_ff[i] <= 8'd0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         if (fire || accept) phase_ff <= phase_in;
         if (fire) begin
            mods_ff    <= mods_in;
            slots_ff   <= slots_in;
            pending_ff <= pending_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff      <= req_op;
         usage_ff   <= req_usage;
         ready_ff   <= req_link_ready;
         accepts_ff <= req_host_accepts;
      end
      if (fire) begin
         attempt_ff   <= attempt_in;
         show_mods_ff <= show_mods_in;
         show_keys_ff <= show_keys_in;
         success_ff   <= success_in;
         owed_ff      <= owed_in;
         last_ff      <= last_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_attempt      = attempt_ff;
   assign rsp_modifiers    = show_mods_ff;
   assign rsp_key_0        = show_keys_ff[0];
   assign rsp_key_1        = show_keys_ff[1];
   assign rsp_key_2        = show_keys_ff[2];
   assign rsp_key_3        = show_keys_ff[3];
   assign rsp_key_4        = show_keys_ff[4];
   assign rsp_key_5        = show_keys_ff[5];
   assign rsp_success      = success_ff;
   assign rsp_release_owed = owed_ff;
   assign rsp_last         = last_ff;

endmodule

### hw/rtl/hkrb_checker.sv
module hkrb_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [1:0] rsp_attempt,
   input logic [7:0] rsp_modifiers,
   input logic [7:0] rsp_key_0,
   input logic [7:0] rsp_key_1,
   input logic [7:0] rsp_key_2,
   input logic [7:0] rsp_key_3,
   input logic [7:0] rsp_key_4,
   input logic [7:0] rsp_key_5,
   input logic       rsp_success,
   input logic       rsp_release_owed,
   input logic       rsp_last
);

   // a stalled result transfer holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_attempt) &&
         $stable(rsp_modifiers) && $stable(rsp_key_0) && $stable(rsp_last))
      else $error("stalled result changed");

   // only a flushed release that went through is followed by a second result
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_attempt == hkrb_pkg::ATT_OK && rsp_success &&
         !rsp_release_owed && rsp_modifiers == 8'd0 && rsp_key_0 == 8'd0 &&
         rsp_key_1 == 8'd0 && rsp_key_2 == 8'd0 && rsp_key_3 == 8'd0 &&
         rsp_key_4 == 8'd0 && rsp_key_5 == 8'd0)
      else $error("bad leading result");

   // a send succeeds exactly when accepted, and a failed send owes a release
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_attempt != hkrb_pkg::ATT_NONE |->
         rsp_success == (rsp_attempt == hkrb_pkg::ATT_OK) &&
         rsp_release_owed != rsp_success)
      else $error("send outcome mismatch");

   // no send while a release is owed is never a success
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_attempt == hkrb_pkg::ATT_NONE && rsp_release_owed |-> !rsp_success)
      else $error("success with release owed");

endmodule

bind hid_keyboard_report_builder_unit hkrb_checker u_hkrb_checker (.*);
